/* hdl/sfc_pkg.sv */
// Shared constants and codes for the SYN flood source counter.
`timescale 1ns / 1ps
package sfc_pkg;

  // Default sizing of the entry pool and the bucket array.
  localparam int unsigned DEF_POOL_ENTRIES = 512;
  localparam int unsigned DEF_HASH_BITS    = 9;

  // Counter width and saturation value.
  localparam int unsigned CNT_W   = 10;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Register reset values.
  localparam logic [CNT_W-1:0] TOTAL_LIMIT_RST   = 10'd512;
  localparam logic [CNT_W-1:0] PER_SRC_LIMIT_RST = 10'd200;

  // Register indexes.
  localparam logic CFG_TOTAL_LIMIT   = 1'b0;
  localparam logic CFG_PER_SRC_LIMIT = 1'b1;

  // Commands.
  localparam logic CMD_NEW     = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // Result codes.
  localparam logic VERDICT_ACCEPT  = 1'b0;
  localparam logic VERDICT_DROP    = 1'b1;
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_NO_ENTRY = 1'b1;

endpackage

/* hdl/sfc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sfc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* hdl/sfc_hash.sv */
// Bucket hash: XOR fold of the source address in HASH_BITS wide chunks.
`timescale 1ns / 1ps
module sfc_hash #(
  parameter int unsigned HASH_BITS = 9
) (
  input  logic [31:0]          addr_i,
  output logic [HASH_BITS-1:0] bucket_o
);

  localparam int unsigned Chunks = (32 + HASH_BITS - 1) / HASH_BITS;

  // Fold all chunks of the address together.
  always_comb begin
    logic [31:0] acc;
    acc = '0;
    for (int k = 0; k < Chunks; k++) begin
      acc = acc ^ (addr_i >> (k * HASH_BITS));
    end
    bucket_o = acc[HASH_BITS-1:0];
  end

endmodule

/* hdl/syn_flood_source_counter_top.sv */
// Top level: per-source SYN counter over a chained hash table in RAM.
// Sequence: after the input transfer the bucket head is read, then the chain entries
//   are walked to a match or the chain end; an insertion also reads the free stack.
// Flow: one item at a time; the next input transfer is taken only once the result is
//   loaded at the output, which waits while an older result is still stalled there.
// Reset: control state clears at once, then a clearing pass empties all 2**HASH_BITS
//   bucket heads; no input is taken during that pass.
`timescale 1ns / 1ps
module syn_flood_source_counter_top #(
  parameter int unsigned POOL_ENTRIES = sfc_pkg::DEF_POOL_ENTRIES,
  parameter int unsigned HASH_BITS    = sfc_pkg::DEF_HASH_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [sfc_pkg::CNT_W-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     command_i,
  input  logic [31:0]              source_address_i,
  input  logic                     whitelisted_i,
  input  logic                     was_counted_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     verdict_o,
  output logic                     flush_and_block_o,
  output logic [sfc_pkg::CNT_W-1:0] source_count_o,
  output logic [sfc_pkg::CNT_W-1:0] total_in_use_o,
  output logic                     status_o
);
  import sfc_pkg::*;

  localparam int unsigned IDXW     = $clog2(POOL_ENTRIES);
  localparam int unsigned FTW      = $clog2(POOL_ENTRIES + 1);
  localparam int unsigned NBUCKETS = 1 << HASH_BITS;
  localparam int unsigned HW       = IDXW + 1;
  localparam int unsigned NOK_POS  = IDXW;
  localparam int unsigned CNT_LO   = IDXW + 1;
  localparam int unsigned ADR_LO   = CNT_LO + CNT_W;
  localparam int unsigned EW       = ADR_LO + 32;
  localparam logic [FTW-1:0] POOL_FT = FTW'(POOL_ENTRIES);
  localparam logic [HASH_BITS-1:0] LAST_BKT = HASH_BITS'(NBUCKETS - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HEAD  = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_EXEC  = 3'd4;
  localparam logic [2:0] S_ALLOC = 3'd5;
  localparam logic [2:0] S_RESP  = 3'd6;

  logic [2:0] state_q, state_d;
  logic [HASH_BITS-1:0] clr_q, clr_d;
  logic [CNT_W-1:0] tl_q, psl_q, total_q, total_d;
  logic [FTW-1:0] free_top_q, free_top_d, low_q, low_d;

  // Item registers.
  logic cmd_q, white_q, cntd_q;
  logic [31:0] addr_q;
  logic [HASH_BITS-1:0] bkt_q, bkt_hash;

  // Lookup registers.
  logic [IDXW-1:0] cur_q, cur_d, prev_idx_q, prev_idx_d, hit_idx_q, hit_idx_d;
  logic [IDXW-1:0] pop_pos_q, pop_pos_d;
  logic pop_lit_q, pop_lit_d;
  logic has_prev_q, has_prev_d, found_q, found_d;
  logic [EW-1:0] prev_word_q, prev_word_d, hit_word_q, hit_word_d;
  logic [HW-1:0] head_word_q, head_word_d;

  // Result registers.
  logic res_verdict_q, res_verdict_d, res_flush_q, res_flush_d, res_status_q, res_status_d;
  logic [CNT_W-1:0] res_src_q, res_src_d;
  logic out_valid_q, out_valid_d, out_load;

  // Memory ports.
  logic head_we, head_re, ent_we, ent_re, free_we, free_re;
  logic [HASH_BITS-1:0] head_waddr, head_raddr;
  logic [HW-1:0] head_wdata, head_rdata;
  logic [IDXW-1:0] ent_waddr, ent_raddr, free_waddr, free_raddr, free_wdata, free_rdata;
  logic [EW-1:0] ent_wdata, ent_rdata;

  logic in_fire;
  logic [CNT_W-1:0] hit_cnt, cnt_new;
  logic [FTW-1:0] pop_ft;
  logic [IDXW-1:0] alloc_idx;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign hit_cnt    = found_q ? hit_word_q[CNT_LO +: CNT_W] : '0;
  assign pop_ft     = free_top_q - FTW'(1);
  assign alloc_idx  = pop_lit_q ? pop_pos_q : free_rdata;

  sfc_hash #(.HASH_BITS(HASH_BITS)) u_hash (
    .addr_i   (source_address_i),
    .bucket_o (bkt_hash)
  );

  sfc_ram #(.WIDTH(HW), .DEPTH(NBUCKETS)) u_head_ram (
    .clk_i, .we_i(head_we), .waddr_i(head_waddr), .wdata_i(head_wdata),
    .re_i(head_re), .raddr_i(head_raddr), .rdata_o(head_rdata)
  );

  sfc_ram #(.WIDTH(EW), .DEPTH(POOL_ENTRIES)) u_entry_ram (
    .clk_i, .we_i(ent_we), .waddr_i(ent_waddr), .wdata_i(ent_wdata),
    .re_i(ent_re), .raddr_i(ent_raddr), .rdata_o(ent_rdata)
  );

  sfc_ram #(.WIDTH(IDXW), .DEPTH(POOL_ENTRIES)) u_free_ram (
    .clk_i, .we_i(free_we), .waddr_i(free_waddr), .wdata_i(free_wdata),
    .re_i(free_re), .raddr_i(free_raddr), .rdata_o(free_rdata)
  );

  // Sequencer: clear, head read, chain walk, update, allocate, respond.
  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    total_d = total_q;
    free_top_d = free_top_q;
    low_d = low_q;
    cur_d = cur_q;
    prev_idx_d = prev_idx_q;
    hit_idx_d = hit_idx_q;
    pop_pos_d = pop_pos_q;
    pop_lit_d = pop_lit_q;
    has_prev_d = has_prev_q;
    found_d = found_q;
    prev_word_d = prev_word_q;
    hit_word_d = hit_word_q;
    head_word_d = head_word_q;
    res_verdict_d = res_verdict_q;
    res_flush_d = res_flush_q;
    res_status_d = res_status_q;
    res_src_d = res_src_q;
    out_load = 1'b0;
    cnt_new = hit_cnt;
    head_we = 1'b0;
    head_waddr = bkt_q;
    head_wdata = '0;
    head_re = 1'b0;
    head_raddr = bkt_hash;
    ent_we = 1'b0;
    ent_waddr = hit_idx_q;
    ent_wdata = hit_word_q;
    ent_re = 1'b0;
    ent_raddr = cur_q;
    free_we = 1'b0;
    free_waddr = free_top_q[IDXW-1:0];
    free_wdata = hit_idx_q;
    free_re = 1'b0;
    free_raddr = pop_ft[IDXW-1:0];

    unique case (state_q)
      S_CLEAR: begin
        head_we = 1'b1;
        head_waddr = clr_q;
        head_wdata = '0;
        clr_d = clr_q + HASH_BITS'(1);
        if (clr_q == LAST_BKT) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          head_re = 1'b1;
          has_prev_d = 1'b0;
          found_d = 1'b0;
          state_d = S_HEAD;
        end
      end
      S_HEAD: begin
        head_word_d = head_rdata;
        if (head_rdata[IDXW]) begin
          ent_re = 1'b1;
          ent_raddr = head_rdata[IDXW-1:0];
          cur_d = head_rdata[IDXW-1:0];
          state_d = S_WALK;
        end else begin
          state_d = S_EXEC;
        end
      end
      S_WALK: begin
        if (ent_rdata[ADR_LO +: 32] == addr_q) begin
          found_d = 1'b1;
          hit_idx_d = cur_q;
          hit_word_d = ent_rdata;
          state_d = S_EXEC;
        end else begin
          prev_word_d = ent_rdata;
          prev_idx_d = cur_q;
          has_prev_d = 1'b1;
          if (ent_rdata[NOK_POS]) begin
            ent_re = 1'b1;
            ent_raddr = ent_rdata[IDXW-1:0];
            cur_d = ent_rdata[IDXW-1:0];
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        res_verdict_d = VERDICT_ACCEPT;
        res_flush_d = 1'b0;
        res_status_d = STATUS_OK;
        res_src_d = hit_cnt;
        state_d = S_RESP;
        if (cmd_q == CMD_NEW) begin
          if (white_q) begin
            res_verdict_d = VERDICT_ACCEPT;
          end else if (total_q >= tl_q) begin
            res_verdict_d = VERDICT_DROP;
          end else if (found_q) begin
            cnt_new = (hit_cnt == CNT_MAX) ? hit_cnt : hit_cnt + CNT_W'(1);
            ent_we = 1'b1;
            ent_wdata = hit_word_q;
            ent_wdata[CNT_LO +: CNT_W] = cnt_new;
            total_d = (total_q == CNT_MAX) ? total_q : total_q + CNT_W'(1);
            res_src_d = cnt_new;
            res_flush_d = cnt_new > psl_q;
          end else if (free_top_q == '0 || free_top_q > POOL_FT) begin
            res_verdict_d = VERDICT_DROP;
          end else begin
            // Pop the free stack; untouched low positions hold their own index.
            free_re = 1'b1;
            pop_pos_d = pop_ft[IDXW-1:0];
            pop_lit_d = pop_ft < low_q;
            free_top_d = pop_ft;
            state_d = S_ALLOC;
          end
        end else if (cntd_q) begin
          if (!found_q) begin
            res_status_d = STATUS_NO_ENTRY;
          end else begin
            cnt_new = (hit_cnt == '0) ? hit_cnt : hit_cnt - CNT_W'(1);
            res_src_d = cnt_new;
            total_d = (total_q == '0) ? total_q : total_q - CNT_W'(1);
            if (cnt_new != '0) begin
              ent_we = 1'b1;
              ent_wdata = hit_word_q;
              ent_wdata[CNT_LO +: CNT_W] = cnt_new;
            end else begin
              // Unlink the entry and push it back on the free stack.
              if (has_prev_q) begin
                ent_we = 1'b1;
                ent_waddr = prev_idx_q;
                ent_wdata = prev_word_q;
                ent_wdata[IDXW:0] = hit_word_q[IDXW:0];
              end else begin
                head_we = 1'b1;
                head_waddr = bkt_q;
                head_wdata = hit_word_q[IDXW:0];
              end
              if (free_top_q < POOL_FT) begin
                free_we = 1'b1;
                free_top_d = free_top_q + FTW'(1);
                if (free_top_q < low_q) begin
                  low_d = free_top_q;
                end
              end
            end
          end
        end
      end
      S_ALLOC: begin
        ent_we = 1'b1;
        ent_waddr = alloc_idx;
        ent_wdata = {addr_q, CNT_W'(1), head_word_q};
        head_we = 1'b1;
        head_waddr = bkt_q;
        head_wdata = {1'b1, alloc_idx};
        total_d = (total_q == CNT_MAX) ? total_q : total_q + CNT_W'(1);
        res_src_d = CNT_W'(1);
        res_flush_d = CNT_W'(1) > psl_q;
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      total_q <= '0;
      free_top_q <= POOL_FT;
      low_q <= POOL_FT;
      out_valid_q <= 1'b0;
      tl_q <= TOTAL_LIMIT_RST;
      psl_q <= PER_SRC_LIMIT_RST;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      total_q <= total_d;
      free_top_q <= free_top_d;
      low_q <= low_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_TOTAL_LIMIT:   tl_q <= cfg_wdata_i;
          CFG_PER_SRC_LIMIT: psl_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= command_i;
      addr_q <= source_address_i;
      white_q <= whitelisted_i;
      cntd_q <= was_counted_i;
      bkt_q <= bkt_hash;
    end
    cur_q <= cur_d;
    prev_idx_q <= prev_idx_d;
    hit_idx_q <= hit_idx_d;
    pop_pos_q <= pop_pos_d;
    pop_lit_q <= pop_lit_d;
    has_prev_q <= has_prev_d;
    found_q <= found_d;
    prev_word_q <= prev_word_d;
    hit_word_q <= hit_word_d;
    head_word_q <= head_word_d;
    res_verdict_q <= res_verdict_d;
    res_flush_q <= res_flush_d;
    res_status_q <= res_status_d;
    res_src_q <= res_src_d;
    if (out_load) begin
      verdict_o <= res_verdict_q;
      flush_and_block_o <= res_flush_q;
      status_o <= res_status_q;
      source_count_o <= res_src_q;
      total_in_use_o <= total_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* hdl/sfc_checker.sv */
// Port-level checker for the SYN flood source counter, bound to the top level.
`timescale 1ns / 1ps
module sfc_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic                      verdict_o,
  input logic                      flush_and_block_o,
  input logic [sfc_pkg::CNT_W-1:0] source_count_o,
  input logic [sfc_pkg::CNT_W-1:0] total_in_use_o,
  input logic                      status_o
);
  import sfc_pkg::*;

  // A stalled result transfer stays valid and keeps its source count and total.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(source_count_o)
      && $stable(total_in_use_o))
    else $error("result changed while stalled");

  // A dropped connection never asks for a flush.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && verdict_o == VERDICT_DROP |-> !flush_and_block_o)
    else $error("flush on a dropped connection");

  // A release without entry reports no count and no drop.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_NO_ENTRY |->
      source_count_o == '0 && verdict_o == VERDICT_ACCEPT && !flush_and_block_o)
    else $error("bad release-without-entry result");

  // A flush follows counting, so source and total are nonzero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && flush_and_block_o |-> source_count_o != '0 && total_in_use_o != '0)
    else $error("flush with zero count");

endmodule

bind syn_flood_source_counter_top sfc_checker u_sfc_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i, .verdict_o, .flush_and_block_o,
  .source_count_o, .total_in_use_o, .status_o
);
